>>> rtl/hrbs_pkg.sv
package hrbs_pkg;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_NUL   = 8'h00;

    localparam logic [1:0] SEP_CRLFCR = 2'd3;
    localparam logic [1:0] SEP_CRLF   = 2'd2;
    localparam logic [1:0] SEP_CR     = 2'd1;
    localparam logic [1:0] SEP_NONE   = 2'd0;

    typedef enum logic [2:0] {
        PH_METHOD   = 3'd0,
        PH_ENDPOINT = 3'd1,
        PH_SKIP     = 3'd2,
        PH_VERSION  = 3'd3,
        PH_HEADER   = 3'd4,
        PH_BODY     = 3'd5,
        PH_DONE     = 3'd6
    } phase_t;

    localparam logic [2:0] TAG_METHOD   = 3'd0;
    localparam logic [2:0] TAG_ENDPOINT = 3'd1;
    localparam logic [2:0] TAG_VERSION  = 3'd2;
    localparam logic [2:0] TAG_DELIM    = 3'd3;
    localparam logic [2:0] TAG_HEADER   = 3'd4;
    localparam logic [2:0] TAG_BODY     = 3'd5;
    localparam logic [2:0] TAG_IGNORED  = 3'd6;

    localparam logic [1:0] ST_OK           = 2'd0;
    localparam logic [1:0] ST_NO_HDR_END   = 2'd1;
    localparam logic [1:0] ST_LINE_INCOMPL = 2'd2;
    localparam logic [1:0] ST_BODY_UNTERM  = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] tagged_byte;
        logic [2:0] field_tag;
        logic       request_end;
        logic [1:0] parse_status;
    } out_beat_t;

endpackage

>>> rtl/hrbs_parser.sv
module hrbs_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  hrbs_pkg::in_beat_t  beat,
    output hrbs_pkg::out_beat_t result
);
    import hrbs_pkg::*;

    phase_t     phase_reg, phase_next, phase_after;
    logic [1:0] sep_reg, sep_next, sep_after;
    logic       incompl_reg, incompl_next, incompl_after;
    logic       in_header;
    logic       sep_done;
    logic [2:0] tag;
    logic [1:0] status;

    assign in_header = (phase_reg == PH_METHOD) || (phase_reg == PH_ENDPOINT) ||
                       (phase_reg == PH_SKIP) || (phase_reg == PH_VERSION) ||
                       (phase_reg == PH_HEADER);
    assign sep_done  = in_header && (beat.data_byte == CH_LF) && (sep_reg == SEP_CRLFCR);

    always_comb
    begin
        phase_after   = phase_reg;
        sep_after     = sep_reg;
        incompl_after = incompl_reg;
        if (in_header)
        begin
            if (sep_done)
                sep_after = SEP_NONE;
            else if (beat.data_byte == CH_CR)
                sep_after = (sep_reg == SEP_CRLF) ? SEP_CRLFCR : SEP_CR;
            else if (beat.data_byte == CH_LF)
                sep_after = (sep_reg == SEP_CR) ? SEP_CRLF : SEP_NONE;
            else
                sep_after = SEP_NONE;

            if (sep_done)
            begin
                if (phase_reg != PH_HEADER)
                    incompl_after = 1'b1;
                phase_after = PH_BODY;
            end
            else
            begin
                unique case (phase_reg)
                    PH_METHOD:
                        if (beat.data_byte == CH_SPACE)
                            phase_after = PH_ENDPOINT;
                    PH_ENDPOINT:
                        if (beat.data_byte == CH_SPACE)
                            phase_after = PH_SKIP;
                    PH_SKIP:
                        if (beat.data_byte == CH_SLASH)
                            phase_after = PH_VERSION;
                    PH_VERSION:
                        if (beat.data_byte == CH_CR)
                            phase_after = PH_HEADER;
                    default:
                        phase_after = phase_reg;
                endcase
            end
        end
        else if (phase_reg == PH_BODY)
        begin
            if (beat.data_byte == CH_NUL)
                phase_after = PH_DONE;
        end
        else
        begin
            phase_after = PH_DONE;
        end

        if (beat.final_byte)
        begin
            phase_next   = PH_METHOD;
            sep_next     = SEP_NONE;
            incompl_next = 1'b0;
        end
        else
        begin
            phase_next   = phase_after;
            sep_next     = sep_after;
            incompl_next = incompl_after;
        end
    end

    always_comb
    begin
        tag = TAG_IGNORED;
        if (sep_done)
            tag = TAG_DELIM;
        else
        begin
            unique case (phase_reg)
                PH_METHOD:
                    tag = (beat.data_byte == CH_SPACE) ? TAG_DELIM : TAG_METHOD;
                PH_ENDPOINT:
                    tag = (beat.data_byte == CH_SPACE) ? TAG_DELIM : TAG_ENDPOINT;
                PH_SKIP:
                    tag = TAG_DELIM;
                PH_VERSION:
                    tag = (beat.data_byte == CH_CR) ? TAG_DELIM : TAG_VERSION;
                PH_HEADER:
                    tag = TAG_HEADER;
                PH_BODY:
                    tag = (beat.data_byte == CH_NUL) ? TAG_DELIM : TAG_BODY;
                default:
                    tag = TAG_IGNORED;
            endcase
        end

        status = ST_OK;
        if (beat.final_byte)
        begin
            if (phase_after != PH_BODY && phase_after != PH_DONE)
                status = ST_NO_HDR_END;
            else if (incompl_after)
                status = ST_LINE_INCOMPL;
            else if (phase_after == PH_BODY)
                status = ST_BODY_UNTERM;
            else
                status = ST_OK;
        end
    end

    assign result.tagged_byte  = beat.data_byte;
    assign result.field_tag    = tag;
    assign result.request_end  = beat.final_byte;
    assign result.parse_status = status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_METHOD;
            sep_reg     <= SEP_NONE;
            incompl_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            sep_reg     <= sep_next;
            incompl_reg <= incompl_next;
        end
    end

endmodule

>>> rtl/hrbs_out_buf.sv
module hrbs_out_buf (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_stall,
    input  hrbs_pkg::out_beat_t push_beat,
    output logic                pop_valid,
    input  logic                pop_stall,
    output hrbs_pkg::out_beat_t pop_beat
);
    import hrbs_pkg::*;

    out_beat_t out_reg, skid_reg;
    logic      out_valid_reg, skid_valid_reg;
    logic      accept, take;

    assign push_stall = skid_valid_reg;
    assign accept     = push_valid && !skid_valid_reg;
    assign take       = out_valid_reg && !pop_stall;
    assign pop_valid  = out_valid_reg;
    assign pop_beat   = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (!out_valid_reg || take)
            begin
                out_valid_reg  <= skid_valid_reg || accept;
                skid_valid_reg <= 1'b0;
            end
            else if (accept)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    // hold payload unless a slot is being loaded
    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || take)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (accept)
                out_reg <= push_beat;
        end
        else if (accept)
        begin
            skid_reg <= push_beat;
        end
    end

endmodule

>>> rtl/http_request_byte_splitter.sv
// Each result is registered in the output buffer after its byte is accepted.
// Throughput: one byte per cycle while result_stall is low; the phase machine
// updates on each accepted beat. A two-entry output buffer absorbs downstream stall
// without losing a beat. Reset (rst_n low, asynchronous): phase returns to method,
// separator match and line-incomplete flag clear, output buffer empties.
module http_request_byte_splitter (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  hrbs_pkg::in_beat_t  item,
    output logic                result_valid,
    input  logic                result_stall,
    output hrbs_pkg::out_beat_t result
);
    import hrbs_pkg::*;

    logic      accept;
    out_beat_t parsed;

    assign accept = item_valid && !item_stall;

    hrbs_parser u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .beat   (item),
        .result (parsed)
    );

    hrbs_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (item_valid),
        .push_stall (item_stall),
        .push_beat  (parsed),
        .pop_valid  (result_valid),
        .pop_stall  (result_stall),
        .pop_beat   (result)
    );

endmodule

>>> rtl/hrbs_checker.sv
module hrbs_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                item_valid,
    input logic                item_stall,
    input hrbs_pkg::in_beat_t  item,
    input logic                result_valid,
    input logic                result_stall,
    input hrbs_pkg::out_beat_t result
);
    import hrbs_pkg::*;

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result beat changed");

    a_status_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.request_end |-> result.parse_status == ST_OK)
        else $error("status set on a beat that does not end the request");

    a_after_nul_status: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.request_end && result.field_tag == TAG_IGNORED
        |-> result.parse_status == ST_OK || result.parse_status == ST_LINE_INCOMPL)
        else $error("bad status for request ended after NUL");

    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> result_valid)
        else $error("accepted beat produced no result");

endmodule

bind http_request_byte_splitter hrbs_checker u_hrbs_checker (.*);

>>> verif/request_tag_checker.sv
module request_tag_checker
    import hrbs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    input  logic      item_stall,
    input  in_beat_t  item,
    input  logic      result_valid,
    input  logic      result_stall,
    input  out_beat_t result,
    output int        fail_count,
    output int        outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    phase_t     phase      = PH_METHOD;
    logic [1:0] sep_match  = SEP_NONE;
    logic       line_short = 1'b0;
    out_beat_t  tag_queue[$];
    out_beat_t  oldest;

    function automatic out_beat_t tag_byte(input in_beat_t b);
        out_beat_t r;
        logic      hdr_done;
        r.tagged_byte  = b.data_byte;
        r.field_tag    = TAG_IGNORED;
        r.request_end  = b.final_byte;
        r.parse_status = ST_OK;
        hdr_done       = 1'b0;
        if (phase <= PH_HEADER)
        begin
            if (b.data_byte == CH_LF && sep_match == SEP_CRLFCR)
            begin
                hdr_done  = 1'b1;
                sep_match = SEP_NONE;
            end
            else if (b.data_byte == CH_CR)
                sep_match = (sep_match == SEP_CRLF) ? SEP_CRLFCR : SEP_CR;
            else if (b.data_byte == CH_LF)
                sep_match = (sep_match == SEP_CR) ? SEP_CRLF : SEP_NONE;
            else
                sep_match = SEP_NONE;

            if (hdr_done)
            begin
                r.field_tag = TAG_DELIM;
                if (phase != PH_HEADER)
                    line_short = 1'b1;
                phase = PH_BODY;
            end
            else
            begin
                case (phase)
                    PH_METHOD:
                    begin
                        if (b.data_byte == CH_SPACE)
                        begin
                            r.field_tag = TAG_DELIM;
                            phase       = PH_ENDPOINT;
                        end
                        else
                            r.field_tag = TAG_METHOD;
                    end
                    PH_ENDPOINT:
                    begin
                        if (b.data_byte == CH_SPACE)
                        begin
                            r.field_tag = TAG_DELIM;
                            phase       = PH_SKIP;
                        end
                        else
                            r.field_tag = TAG_ENDPOINT;
                    end
                    PH_SKIP:
                    begin
                        r.field_tag = TAG_DELIM;
                        if (b.data_byte == CH_SLASH)
                            phase = PH_VERSION;
                    end
                    PH_VERSION:
                    begin
                        if (b.data_byte == CH_CR)
                        begin
                            r.field_tag = TAG_DELIM;
                            phase       = PH_HEADER;
                        end
                        else
                            r.field_tag = TAG_VERSION;
                    end
                    default:
                        r.field_tag = TAG_HEADER;
                endcase
            end
        end
        else if (phase == PH_BODY)
        begin
            if (b.data_byte == CH_NUL)
            begin
                r.field_tag = TAG_DELIM;
                phase       = PH_DONE;
            end
            else
                r.field_tag = TAG_BODY;
        end
        else
        begin
            r.field_tag = TAG_IGNORED;
            phase       = PH_DONE;
        end

        if (b.final_byte)
        begin
            if (phase <= PH_HEADER)
                r.parse_status = ST_NO_HDR_END;
            else if (line_short)
                r.parse_status = ST_LINE_INCOMPL;
            else if (phase == PH_BODY)
                r.parse_status = ST_BODY_UNTERM;
            else
                r.parse_status = ST_OK;
            phase      = PH_METHOD;
            sep_match  = SEP_NONE;
            line_short = 1'b0;
        end
        return r;
    endfunction

    task automatic note_mismatch(input string what, input out_beat_t want,
                                 input out_beat_t got);
        fail_count++;
        if (fail_count <= 10)
        begin
            $write("%0t %s: exp byte=%h tag=%0d end=%b status=%0d, ",
                   $realtime, what, want.tagged_byte, want.field_tag, want.request_end,
                   want.parse_status);
            $display("got byte=%h tag=%0d end=%b status=%0d",
                     got.tagged_byte, got.field_tag, got.request_end, got.parse_status);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase       = PH_METHOD;
            sep_match   = SEP_NONE;
            line_short  = 1'b0;
            tag_queue.delete();
            fail_count  = 0;
            outstanding = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (tag_queue.size() == 0)
                    note_mismatch("unexpected beat", '0, result);
                else
                begin
                    oldest = tag_queue.pop_front();
                    if (oldest.tagged_byte !== result.tagged_byte
                        || oldest.field_tag !== result.field_tag
                        || oldest.request_end !== result.request_end
                        || oldest.parse_status !== result.parse_status)
                        note_mismatch("field mismatch", oldest, result);
                end
            end
            if (item_valid && !item_stall)
                tag_queue.push_back(tag_byte(item));
            outstanding = tag_queue.size();
        end
    end

endmodule

>>> verif/tb_http_request_byte_splitter.sv
module tb_http_request_byte_splitter;
    timeunit 1ns;
    timeprecision 1ps;

    import hrbs_pkg::*;

    localparam int RANDOM_BYTES   = 900;
    localparam int HOLD_CYCLES    = 200;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;

    logic      clk          = 1'b0;
    logic      rst_n        = 1'b0;
    logic      item_valid   = 1'b0;
    logic      item_stall;
    in_beat_t  item         = '0;
    logic      result_valid;
    logic      result_stall = 1'b0;
    out_beat_t result;

    int         fail_count;
    int         outstanding;
    int         sent         = 0;
    int         quiet_cycles = 0;
    bit         tx_quiet     = 1'b0;
    bit         rx_quiet     = 1'b0;
    bit         hold_req     = 1'b0;
    logic [7:0] req[$];

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    http_request_byte_splitter u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    request_tag_checker u_chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .fail_count   (fail_count),
        .outstanding  (outstanding)
    );

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // hold off the receiver on request so the block backs up into its input
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            result_stall <= !rx_quiet && ($urandom_range(99) < 6);
        end
    end

    task automatic offer_beat(input logic [7:0] b, input logic last);
        if (!tx_quiet)
            while ($urandom_range(99) < 6)
            begin
                item_valid <= 1'b0;
                @(posedge clk);
            end
        item_valid <= 1'b1;
        item       <= '{data_byte: b, final_byte: last};
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        sent++;
    endtask

    task automatic send_request();
        for (int i = 0; i < req.size(); i++)
            offer_beat(req[i], i == req.size() - 1);
        req.delete();
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            req.push_back(s[i]);
    endtask

    task automatic push_crlf();
        req.push_back(CH_CR);
        req.push_back(CH_LF);
    endtask

    task automatic push_word(input int lo, input int hi);
        int n;
        n = $urandom_range(hi, lo);
        repeat (n)
            req.push_back($urandom_range(1) ? 8'($urandom_range(8'h7A, 8'h61))
                                            : 8'($urandom_range(8'h5A, 8'h41)));
    endtask

    function automatic logic [7:0] noise_byte();
        case ($urandom_range(7))
            0: return CH_CR;
            1: return CH_LF;
            2: return CH_SPACE;
            3: return CH_SLASH;
            4: return CH_NUL;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic build_request();
        int kind;
        int n;
        kind = $urandom_range(99);
        if (kind < 20)
        begin
            n = $urandom_range(12, 1);
            repeat (n)
                req.push_back(noise_byte());
            return;
        end
        push_word(1, 7);
        if (kind < 28)
        begin
            // header ends inside the request line
            if ($urandom_range(1))
            begin
                req.push_back(CH_SPACE);
                push_word(0, 4);
            end
            push_crlf();
            push_crlf();
            push_word(0, 3);
            if ($urandom_range(1))
                req.push_back(CH_NUL);
            return;
        end
        req.push_back(CH_SPACE);
        req.push_back(CH_SLASH);
        push_word(0, 8);
        req.push_back(CH_SPACE);
        push_text("HTTP/1.");
        req.push_back(8'($urandom_range(8'h31, 8'h30)));
        push_crlf();
        n = $urandom_range(3);
        repeat (n)
        begin
            push_word(1, 6);
            push_text(": ");
            push_word(1, 10);
            push_crlf();
        end
        push_crlf();
        n = $urandom_range(8);
        repeat (n)
            req.push_back(8'($urandom_range(255, 1)));
        if ($urandom_range(3) != 0)
        begin
            req.push_back(CH_NUL);
            n = $urandom_range(3);
            repeat (n)
                req.push_back(noise_byte());
        end
        if (kind < 40)
        begin
            n = $urandom_range(req.size(), 1);
            while (req.size() > n)
                void'(req.pop_back());
        end
    endtask

    initial
    begin
        int  start_count;
        bit  hold_done;
        hold_done = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // complete request with body, terminator and a trailing byte
        push_text("A B ");
        req.push_back(CH_SLASH);
        push_text("1");
        push_crlf();
        push_crlf();
        push_text("x");
        req.push_back(CH_NUL);
        req.push_back(8'hFF);
        send_request();
        // lone byte, no header end
        req.push_back(8'hFF);
        send_request();
        // separator before the request line closes
        push_crlf();
        push_crlf();
        send_request();
        // empty body without terminator
        push_text("a  ");
        req.push_back(CH_SLASH);
        push_crlf();
        push_crlf();
        send_request();

        start_count = sent;
        while (sent - start_count < RANDOM_BYTES)
        begin
            if (!hold_done && sent - start_count > 300)
            begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            tx_quiet = (sent - start_count >= 550) && (sent - start_count < 750);
            rx_quiet = tx_quiet;
            build_request();
            send_request();
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
        item_valid <= 1'b0;

        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
